/* hdl/tsr_pkg.sv */
package tsr_pkg;

	// Depth of the fragment store in bytes.
	localparam int BUF_DEPTH = 2048;
	localparam int BUF_AW = $clog2(BUF_DEPTH);

	localparam logic [11:0] MAX_FRAG_RESET = 12'd2048;

	typedef enum logic [1:0] {
		REQ_HEADER = 2'd0,
		REQ_BYTE   = 2'd1,
		REQ_READ   = 2'd2,
		REQ_EMPTY  = 2'd3
	} req_kind_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NO_HDR    = 3'd1,
		ST_PRIOR_DSC = 3'd2,
		ST_NO_PRIOR  = 3'd3,
		ST_BAD_SEQ   = 3'd4,
		ST_BAD_ADDR  = 3'd5,
		ST_OVERFLOW  = 3'd6,
		ST_DROPPED   = 3'd7
	} status_t;

	typedef struct packed {
		req_kind_t   kind;
		logic [7:0]  header_byte;
		logic [7:0]  payload_len;
		logic [15:0] src_addr;
		logic [15:0] dst_addr;
		logic [7:0]  data_byte;
		logic [10:0] read_index;
	} req_t;

	// Everything in a result except the byte read back from the store.
	typedef struct packed {
		status_t     status;
		logic        frag_done;
		logic [11:0] frag_len;
		logic [15:0] frag_src;
		logic [15:0] frag_dst;
		logic        rd_ok;
	} res_t;

endpackage

/* hdl/tsr_ram.sv */
module tsr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hdl/tsr_ctrl.sv */
module tsr_ctrl import tsr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [11:0]       cfg_wdata,
	input  logic              step,
	input  req_t              req,
	output res_t              res,
	output logic              st_we,
	output logic [BUF_AW-1:0] st_waddr,
	output logic [7:0]        st_wdata,
	output logic              st_re,
	output logic [BUF_AW-1:0] st_raddr
);

	logic [11:0] max_frag_q;
	logic [11:0] byte_count_q, byte_count_d;
	logic [5:0]  exp_seq_q, exp_seq_d;
	logic [15:0] last_src_q, last_src_d;
	logic [15:0] last_dst_q, last_dst_d;
	logic        seg_active_q, seg_active_d;
	logic [7:0]  seg_rem_q, seg_rem_d;
	logic        seg_fin_q, seg_fin_d;

	logic        fin, fir;
	logic [5:0]  seq;
	logic [11:0] bc0, bc1, cap, room, bc_inc;
	status_t     hdr_status;

	assign fin = req.header_byte[7];
	assign fir = req.header_byte[6];
	assign seq = req.header_byte[5:0];
	assign bc_inc = byte_count_q + 12'd1;

	// Capacity is the register value clipped to the store depth.
	assign cap = (32'(max_frag_q) > BUF_DEPTH) ? 12'(BUF_DEPTH) : max_frag_q;

	always_comb begin
		// A pending segment that is cut off by a new header loses the fragment.
		bc0 = seg_active_q ? 12'd0 : byte_count_q;
		if (fir && bc0 != 12'd0) begin
			bc1 = 12'd0;
			hdr_status = ST_PRIOR_DSC;
		end else begin
			bc1 = bc0;
			hdr_status = ST_OK;
		end
		room = (bc1 < cap) ? cap - bc1 : 12'd0;
	end

	always_comb begin
		byte_count_d = byte_count_q;
		exp_seq_d = exp_seq_q;
		last_src_d = last_src_q;
		last_dst_d = last_dst_q;
		seg_active_d = seg_active_q;
		seg_rem_d = seg_rem_q;
		seg_fin_d = seg_fin_q;
		res = '0;
		res.status = ST_OK;
		st_we = 1'b0;
		st_wdata = req.data_byte;
		st_waddr = BUF_AW'(byte_count_q);
		st_re = 1'b0;
		st_raddr = BUF_AW'(req.read_index);

		unique case (req.kind)
			REQ_HEADER: begin
				seg_active_d = 1'b0;
				seg_rem_d = 8'd0;
				seg_fin_d = 1'b0;
				byte_count_d = bc1;
				if (!fir && bc1 == 12'd0) begin
					res.status = ST_NO_PRIOR;
				end else if (!fir && seq != exp_seq_q) begin
					res.status = ST_BAD_SEQ;
				end else if (!fir && (req.src_addr != last_src_q
						|| req.dst_addr != last_dst_q)) begin
					res.status = ST_BAD_ADDR;
				end else if ({4'd0, req.payload_len} > room) begin
					byte_count_d = 12'd0;
					res.status = ST_OVERFLOW;
				end else begin
					last_src_d = req.src_addr;
					last_dst_d = req.dst_addr;
					exp_seq_d = seq + 6'd1;
					res.status = hdr_status;
					if (req.payload_len == 8'd0) begin
						if (fin) begin
							res.frag_done = 1'b1;
							res.frag_len = bc1;
							res.frag_src = req.src_addr;
							res.frag_dst = req.dst_addr;
							byte_count_d = 12'd0;
						end
					end else begin
						seg_active_d = 1'b1;
						seg_rem_d = req.payload_len;
						seg_fin_d = fin;
					end
				end
			end
			REQ_BYTE: begin
				if (!seg_active_q) begin
					res.status = ST_DROPPED;
				end else begin
					st_we = 32'(byte_count_q) < BUF_DEPTH;
					byte_count_d = bc_inc;
					seg_rem_d = seg_rem_q - 8'd1;
					if (seg_rem_q == 8'd1) begin
						seg_active_d = 1'b0;
						seg_fin_d = 1'b0;
						if (seg_fin_q) begin
							res.frag_done = 1'b1;
							res.frag_len = bc_inc;
							res.frag_src = last_src_q;
							res.frag_dst = last_dst_q;
							byte_count_d = 12'd0;
						end
					end
				end
			end
			REQ_READ: begin
				st_re = 1'b1;
				res.rd_ok = 32'(req.read_index) < BUF_DEPTH;
			end
			REQ_EMPTY: begin
				res.status = ST_NO_HDR;
			end
			default: begin
				res.status = ST_NO_HDR;
			end
		endcase

		// Nothing touches the fragment state or the store unless the item is accepted.
		if (!step) begin
			st_we = 1'b0;
			st_re = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frag_q <= MAX_FRAG_RESET;
			byte_count_q <= '0;
			exp_seq_q <= '0;
			last_src_q <= '0;
			last_dst_q <= '0;
			seg_active_q <= 1'b0;
			seg_rem_q <= '0;
			seg_fin_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_frag_q <= cfg_wdata;
			end
			if (step) begin
				byte_count_q <= byte_count_d;
				exp_seq_q <= exp_seq_d;
				last_src_q <= last_src_d;
				last_dst_q <= last_dst_d;
				seg_active_q <= seg_active_d;
				seg_rem_q <= seg_rem_d;
				seg_fin_q <= seg_fin_d;
			end
		end
	end

endmodule

/* hdl/transport_segment_reassembler.sv */
// A result beat is registered and appears in the cycle after its input beat is accepted.
// One beat is taken per cycle while the sink keeps m_tready high; the header
// check, the store write and the store read all finish in the cycle the beat is accepted.
// Reset (arst_n low) clears the fragment state, empties the output register
// and sets max_frag_size to 2048; the fragment store itself is not cleared.
module transport_segment_reassembler import tsr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_we,
	input  logic [11:0] cfg_wdata,   // max_frag_size

	input  logic        s_tvalid,
	output logic        s_tready,
	// tdata from bit 0: header_byte[7:0], payload_len[15:8], src_addr[31:16],
	// dst_addr[47:32], data_byte[55:48], read_index[66:56], zero pad [71:67]
	input  logic [71:0] s_tdata,
	input  logic [1:0]  s_tuser,     // req_type

	output logic        m_tvalid,
	input  logic        m_tready,
	// tdata from bit 0: frag_done[0], frag_len[12:1], frag_src[28:13],
	// frag_dst[44:29], read_data[52:45], zero pad [55:53]
	output logic [55:0] m_tdata,
	output logic [2:0]  m_tuser      // status
);

	// The output register is the only stage. A new beat is taken whenever the
	// register is empty or its beat is leaving in this cycle, so the input
	// side keeps moving while a result waits as long as the sink drains it.
	logic              accept;
	req_t              req;
	res_t              res, res_s1;
	logic              out_valid_s1;
	logic              st_we, st_re;
	logic [BUF_AW-1:0] st_waddr, st_raddr;
	logic [7:0]        st_wdata, st_rdata;
	logic [7:0]        read_data;

	assign s_tready = !out_valid_s1 || m_tready;
	assign accept = s_tvalid && s_tready;

	assign req.kind = req_kind_t'(s_tuser);
	assign req.header_byte = s_tdata[7:0];
	assign req.payload_len = s_tdata[15:8];
	assign req.src_addr = s_tdata[31:16];
	assign req.dst_addr = s_tdata[47:32];
	assign req.data_byte = s_tdata[55:48];
	assign req.read_index = s_tdata[66:56];

	// Header checks, byte counting and fragment completion.
	tsr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.step     (accept),
		.req      (req),
		.res      (res),
		.st_we    (st_we),
		.st_waddr (st_waddr),
		.st_wdata (st_wdata),
		.st_re    (st_re),
		.st_raddr (st_raddr)
	);

	// Fragment store. Its read data register is read only on an accepted read
	// beat, so it holds the byte steady while the result waits in the output
	// register. A beat never reads and writes at once, and every earlier write
	// has landed before a later read is issued.
	tsr_ram #(
		.WIDTH(8),
		.DEPTH(BUF_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (st_we),
		.waddr(st_waddr),
		.wdata(st_wdata),
		.re   (st_re),
		.raddr(st_raddr),
		.rdata(st_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			out_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
		end
	end

	// Only in-range read beats carry a store byte; all others report zero.
	assign read_data = res_s1.rd_ok ? st_rdata : 8'd0;

	assign m_tvalid = out_valid_s1;
	assign m_tuser = res_s1.status;
	assign m_tdata = {3'd0, read_data, res_s1.frag_dst, res_s1.frag_src,
		res_s1.frag_len, res_s1.frag_done};

endmodule
